>>> src/psg_pkg.sv
package psg_pkg;

  localparam int MAX_LIMIT_DEF = 256;
  localparam int CFG_W         = 9;
  localparam int PRIME_W       = 8;
  localparam int CNT_W         = 6;
  localparam int STEP_W        = 4;

  localparam logic [CFG_W-1:0] LIMIT_RST = 9'd100;
  localparam int FIRST_PRIME = 2;

  typedef logic [STEP_W-1:0] step_t;

  // microprogram step addresses
  localparam step_t S_IDLE    = 4'd0;
  localparam step_t S_FILL    = 4'd1;
  localparam step_t S_SV_INIT = 4'd2;
  localparam step_t S_SV_RD   = 4'd3;
  localparam step_t S_SV_TEST = 4'd4;
  localparam step_t S_STRIKE  = 4'd5;
  localparam step_t S_SV_NEXT = 4'd6;
  localparam step_t S_CNT     = 4'd7;
  localparam step_t S_EM_INIT = 4'd8;
  localparam step_t S_EM_RD   = 4'd9;
  localparam step_t S_EMIT    = 4'd10;
  localparam step_t S_EM_END  = 4'd11;

  typedef enum logic [1:0] {
    I_HOLD = 2'd0,
    I_ZERO = 2'd1,
    I_TWO  = 2'd2,
    I_INC  = 2'd3
  } i_op_t;

  typedef enum logic [1:0] {
    J_HOLD   = 2'd0,
    J_DOUBLE = 2'd1,
    J_ADD    = 2'd2
  } j_op_t;

  typedef enum logic [1:0] {
    CNT_HOLD  = 2'd0,
    CNT_CLEAR = 2'd1,
    CNT_MARK  = 2'd2
  } cnt_op_t;

  typedef enum logic [1:0] {
    WR_NONE   = 2'd0,
    WR_FILL   = 2'd1,
    WR_STRIKE = 2'd2
  } wr_op_t;

  typedef enum logic {
    RA_I    = 1'b0,
    RA_NEXT = 1'b1
  } ra_op_t;

  typedef enum logic [1:0] {
    OUT_NONE  = 2'd0,
    OUT_PRIME = 2'd1,
    OUT_EMPTY = 2'd2
  } out_op_t;

  typedef enum logic [2:0] {
    COND_NEVER     = 3'd0,
    COND_ALWAYS    = 3'd1,
    COND_IDLE_WAIT = 3'd2,
    COND_I1_LT_LIM = 3'd3,
    COND_SQ_GE_LIM = 3'd4,
    COND_NOT_MARK  = 3'd5,
    COND_J_LT_LIM  = 3'd6
  } cond_sel_t;

  typedef struct packed {
    logic      busy;
    i_op_t     i_op;
    j_op_t     j_op;
    cnt_op_t   cnt_op;
    wr_op_t    wr_op;
    ra_op_t    ra_op;
    out_op_t   out_op;
    cond_sel_t cond;
    step_t     target;
  } ucode_t;

  typedef struct packed {
    logic go;
    logic i1_lt_lim;
    logic sq_ge_lim;
    logic mark;
    logic j_lt_lim;
  } flags_t;

  // control store: one word per step, jump to target when cond holds
  function automatic ucode_t ucode(input step_t pc);
    ucode_t w;
    w.busy   = 1'b1;
    w.i_op   = I_HOLD;
    w.j_op   = J_HOLD;
    w.cnt_op = CNT_HOLD;
    w.wr_op  = WR_NONE;
    w.ra_op  = RA_I;
    w.out_op = OUT_NONE;
    w.cond   = COND_NEVER;
    w.target = S_IDLE;
    unique case (pc)
      S_IDLE: begin
        w.busy   = 1'b0;
        w.i_op   = I_ZERO;
        w.cnt_op = CNT_CLEAR;
        w.cond   = COND_IDLE_WAIT;
        w.target = S_IDLE;
      end
      S_FILL: begin
        w.i_op   = I_INC;
        w.wr_op  = WR_FILL;
        w.cond   = COND_I1_LT_LIM;
        w.target = S_FILL;
      end
      S_SV_INIT: begin
        w.i_op = I_TWO;
      end
      S_SV_RD: begin
        w.cond   = COND_SQ_GE_LIM;
        w.target = S_CNT;
      end
      S_SV_TEST: begin
        w.j_op   = J_DOUBLE;
        w.cnt_op = CNT_MARK;
        w.cond   = COND_NOT_MARK;
        w.target = S_SV_NEXT;
      end
      S_STRIKE: begin
        w.j_op   = J_ADD;
        w.wr_op  = WR_STRIKE;
        w.cond   = COND_J_LT_LIM;
        w.target = S_STRIKE;
      end
      S_SV_NEXT: begin
        w.i_op   = I_INC;
        w.cond   = COND_ALWAYS;
        w.target = S_SV_RD;
      end
      S_CNT: begin
        w.i_op   = I_INC;
        w.cnt_op = CNT_MARK;
        w.ra_op  = RA_NEXT;
        w.cond   = COND_I1_LT_LIM;
        w.target = S_CNT;
      end
      S_EM_INIT: begin
        w.i_op = I_TWO;
      end
      S_EM_RD: begin
        w.cond = COND_NEVER;
      end
      S_EMIT: begin
        w.i_op   = I_INC;
        w.ra_op  = RA_NEXT;
        w.out_op = OUT_PRIME;
        w.cond   = COND_I1_LT_LIM;
        w.target = S_EMIT;
      end
      S_EM_END: begin
        w.out_op = OUT_EMPTY;
        w.cond   = COND_ALWAYS;
        w.target = S_IDLE;
      end
      default: begin
        w.busy   = 1'b0;
        w.cond   = COND_ALWAYS;
        w.target = S_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

>>> src/psg_ram.sv
module psg_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/psg_seq.sv
module psg_seq (
  input  logic             clk,
  input  logic             rst,
  input  psg_pkg::flags_t  flags,
  output psg_pkg::ucode_t  ctrl
);

  psg_pkg::step_t pc;
  psg_pkg::step_t pc_next;
  logic           take;

  always_comb begin
    ctrl = psg_pkg::ucode(pc);
  end

  // branch condition select
  always_comb begin
    unique case (ctrl.cond)
      psg_pkg::COND_NEVER:     take = 1'b0;
      psg_pkg::COND_ALWAYS:    take = 1'b1;
      psg_pkg::COND_IDLE_WAIT: take = ~flags.go;
      psg_pkg::COND_I1_LT_LIM: take = flags.i1_lt_lim;
      psg_pkg::COND_SQ_GE_LIM: take = flags.sq_ge_lim;
      psg_pkg::COND_NOT_MARK:  take = ~flags.mark;
      psg_pkg::COND_J_LT_LIM:  take = flags.j_lt_lim;
      default:                 take = 1'b1;
    endcase
    pc_next = take ? ctrl.target : psg_pkg::step_t'(pc + 1'b1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= psg_pkg::S_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

>>> src/prime_sieve_generator_core.sv
// prime sieve generator: lists the primes strictly below a programmed limit
//
// config channel: cfg_valid/cfg_ready/cfg_limit writes the 9-bit limit; ready
//   only while idle. limit below 2 acts as 2, above MAX_LIMIT as MAX_LIMIT.
// command: a beat is taken when start is high and busy is low; start_req
//   must be 1 for a run, a beat with start_req 0 does nothing.
// results: one beat per prime in rising order, each shown for one cycle with
//   result_valid high, carrying position, found_count and is_last. when no
//   prime exists a single beat with none_found and is_last set comes out.
//   the receiver cannot stall, so results are never held.
// sequence: one run at a time. fill the mark memory for every entry below
//   limit, then sieve each i with i*i below limit: read its mark and, if
//   it is prime, strike out each multiple from 2*i up. then count from the
//   first i with i*i at or above limit, then emit each entry from 2 on in
//   turn. prime beats show while busy is high; the empty beat shows in the
//   first idle cycle, where the next command may already be taken.
// reset: limit returns to 100, the sequencer goes idle, no beat pending.
//   the mark memory is not cleared; each run refills what it reads.
module prime_sieve_generator_core #(
  parameter int MAX_LIMIT = psg_pkg::MAX_LIMIT_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  // command channel
  input  logic                        start,
  output logic                        busy,
  input  logic                        start_req,
  // config write channel
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [psg_pkg::CFG_W-1:0]   cfg_limit,
  // result beats
  output logic                        result_valid,
  output logic [psg_pkg::PRIME_W-1:0] prime,
  output logic [psg_pkg::CNT_W-1:0]   position,
  output logic [psg_pkg::CNT_W-1:0]   found_count,
  output logic                        is_last,
  output logic                        none_found
);

  localparam int LIM_W  = $clog2(MAX_LIMIT + 1);
  localparam int J_W    = LIM_W + 1;
  localparam int ADDR_W = $clog2(MAX_LIMIT);
  localparam int SQ_W   = 2 * LIM_W;

  psg_pkg::ucode_t ctrl;
  psg_pkg::flags_t flags;

  // programmed limit and the clamped copy latched for a run
  logic [psg_pkg::CFG_W-1:0] limit;
  logic [LIM_W-1:0]          eff_lim;
  logic [LIM_W-1:0]          lim;

  // datapath registers
  logic [LIM_W-1:0]          i;
  logic [J_W-1:0]            j;
  logic [psg_pkg::CNT_W-1:0] count;
  logic [psg_pkg::CNT_W-1:0] emitted;

  logic              go;
  logic              live;
  logic              mark;
  logic [SQ_W-1:0]   i_sq;
  logic [J_W-1:0]    i_ext;
  logic              hit;

  // mark memory port
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [0:0]        ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [0:0]        ram_rdata;

  assign busy      = ctrl.busy;
  assign cfg_ready = ~ctrl.busy;
  assign go        = start & ~ctrl.busy & start_req;

  // clamp the programmed limit into 2..MAX_LIMIT
  always_comb begin
    if (limit < psg_pkg::CFG_W'(psg_pkg::FIRST_PRIME)) begin
      eff_lim = LIM_W'(psg_pkg::FIRST_PRIME);
    end else if (limit > psg_pkg::CFG_W'(MAX_LIMIT)) begin
      eff_lim = LIM_W'(MAX_LIMIT);
    end else begin
      eff_lim = LIM_W'(limit);
    end
  end

  assign i_ext = J_W'(i);
  assign i_sq  = SQ_W'(i) * SQ_W'(i);
  assign mark  = ram_rdata[0];
  // rdata always holds the mark of the current i in the scan steps
  assign live  = i < lim;
  assign hit   = mark & live;

  always_comb begin
    flags.go        = go;
    flags.i1_lt_lim = (i_ext + J_W'(1)) < J_W'(lim);
    flags.sq_ge_lim = i_sq >= SQ_W'(lim);
    flags.mark      = mark;
    flags.j_lt_lim  = j < J_W'(lim);
  end

  psg_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .ctrl  (ctrl)
  );

  // memory addressing: fill walks i, strikes walk j, scans read one ahead
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ADDR_W'(i);
    ram_wdata = 1'b0;
    unique case (ctrl.wr_op)
      psg_pkg::WR_NONE: begin
        ram_we = 1'b0;
      end
      psg_pkg::WR_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = ADDR_W'(i);
        ram_wdata = (i >= LIM_W'(psg_pkg::FIRST_PRIME));
      end
      psg_pkg::WR_STRIKE: begin
        ram_we    = flags.j_lt_lim;
        ram_waddr = ADDR_W'(j);
        ram_wdata = 1'b0;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
    unique case (ctrl.ra_op)
      psg_pkg::RA_I:    ram_raddr = ADDR_W'(i);
      psg_pkg::RA_NEXT: ram_raddr = ADDR_W'(i_ext + J_W'(1));
      default:          ram_raddr = ADDR_W'(i);
    endcase
  end

  psg_ram #(
    .WIDTH (1),
    .DEPTH (MAX_LIMIT)
  ) u_marks (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      limit        <= psg_pkg::LIMIT_RST;
      result_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        limit <= cfg_limit;
      end
      unique case (ctrl.out_op)
        psg_pkg::OUT_NONE:  result_valid <= 1'b0;
        psg_pkg::OUT_PRIME: result_valid <= hit;
        psg_pkg::OUT_EMPTY: result_valid <= (count == '0);
        default:            result_valid <= 1'b0;
      endcase
    end
  end

  // datapath and result payload
  always_ff @(posedge clk) begin
    if (go) begin
      lim <= eff_lim;
    end

    unique case (ctrl.i_op)
      psg_pkg::I_HOLD: i <= i;
      psg_pkg::I_ZERO: i <= '0;
      psg_pkg::I_TWO:  i <= LIM_W'(psg_pkg::FIRST_PRIME);
      psg_pkg::I_INC:  i <= LIM_W'(i_ext + J_W'(1));
      default:         i <= i;
    endcase

    unique case (ctrl.j_op)
      psg_pkg::J_HOLD:   j <= j;
      psg_pkg::J_DOUBLE: j <= i_ext + i_ext;
      psg_pkg::J_ADD:    j <= j + i_ext;
      default:           j <= j;
    endcase

    unique case (ctrl.cnt_op)
      psg_pkg::CNT_HOLD: begin
        count <= count;
      end
      psg_pkg::CNT_CLEAR: begin
        count   <= '0;
        emitted <= '0;
      end
      psg_pkg::CNT_MARK: begin
        if (hit) begin
          count <= count + 1'b1;
        end
      end
      default: begin
        count <= count;
      end
    endcase

    unique case (ctrl.out_op)
      psg_pkg::OUT_NONE: begin
        prime <= prime;
      end
      psg_pkg::OUT_PRIME: begin
        prime       <= psg_pkg::PRIME_W'(i);
        position    <= emitted;
        found_count <= count;
        is_last     <= (emitted + 1'b1) == count;
        none_found  <= 1'b0;
        if (hit) begin
          emitted <= emitted + 1'b1;
        end
      end
      psg_pkg::OUT_EMPTY: begin
        prime       <= '0;
        position    <= '0;
        found_count <= '0;
        is_last     <= 1'b1;
        none_found  <= 1'b1;
      end
      default: begin
        prime <= prime;
      end
    endcase
  end

`ifndef SYNTHESIS
  // a taken run request always starts the sequencer
  a_go_busy: assert property (@(posedge clk) disable iff (rst)
    go |=> busy)
    else $error("run request did not start the sequencer");

  // a prime beat sits inside the list it reports
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !none_found) |-> (position < found_count))
    else $error("prime position beyond found count");

  // the empty beat is the single last beat with a zero count
  a_empty_beat: assert property (@(posedge clk) disable iff (rst)
    (result_valid && none_found) |-> (is_last && found_count == '0))
    else $error("empty beat malformed");

  // every reported prime lies below the latched limit
  a_prime_range: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !none_found) |-> (int'(prime) < int'(lim)))
    else $error("prime not below limit");

  // no beat while the sequencer stays idle past its first idle cycle
  a_quiet_idle: assert property (@(posedge clk) disable iff (rst)
    (!busy && $past(!busy)) |-> !result_valid)
    else $error("result beat while idle");
`endif

endmodule
